/* hw/rtl/acsa_pkg.sv */
`default_nettype none
package acsa_pkg;

   localparam int TRIG_BITS_DEFAULT = 10;

   localparam logic [15:0] DIM_RESET     = 16'd450;
   localparam logic [15:0] TRACK_RESET   = 16'd5000;
   localparam logic [15:0] STEP_RESET    = 16'd100;
   localparam logic [7:0]  HISTORY_RESET = 8'd10;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [1:0] {
      REG_VEHICLE_DIMENSION = 2'd0,
      REG_TRACKING_DISTANCE = 2'd1,
      REG_MAX_SPEED_STEP    = 2'd2,
      REG_HISTORY_LIMIT     = 2'd3
   } reg_index_type;

   localparam logic [16:0] BEARING_OFFSET = 17'd46080;
   localparam logic [31:0] K_ROUND        = 32'd23040;
   // floor(x / 45) for x below 2^21 as (x * K_RECIP) >> 27
   localparam logic [21:0] K_RECIP        = 22'd2982617;
   localparam logic [31:0] CMD_ROUND      = 32'd900;
   // floor(x / 225) for x below 2^24 as (x * CMD_RECIP) >> 32
   localparam logic [24:0] CMD_RECIP      = 25'd19088744;
   localparam logic [15:0] SAME_BEARING   = 16'd640;

   typedef struct packed {
      logic [15:0] vehicle_dimension;
      logic [15:0] tracking_distance;
      logic [15:0] max_speed_step;
      logic [7:0]  history_limit;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic div_k;
      logic div_load_cmd;
      logic div_cmd;
      logic mul_lat;
      logic mul_fwd;
      logic eval;
      logic decide;
   } cmd_type;

   typedef struct packed {
      logic last_item;
      logic out_busy;
   } sts_type;

   function automatic logic [15:0] quarter_sine(input int r, input int bits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] one;
      one = 64'd1 << 30;
      x = (64'(r) * 64'd1686629713) >> (bits - 2);
      x2 = (x * x) >> 30;
      t = one;
      t = one - (((x2 * t) >> 30) / 64'd110);
      t = one - (((x2 * t) >> 30) / 64'd72);
      t = one - (((x2 * t) >> 30) / 64'd42);
      t = one - (((x2 * t) >> 30) / 64'd20);
      t = one - (((x2 * t) >> 30) / 64'd6);
      s = (x * t) >> 30;
      s = (s + 64'd16384) >> 15;
      if (s > 64'd32768) s = 64'd32768;
      return s[15:0];
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/acsa_csr.sv */
`default_nettype none
module acsa_csr import acsa_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                          csr_pready,
   output cfg_type                       cfg
);
   cfg_type cfg_ff, cfg_in;
   reg_index_type idx;

   assign idx = reg_index_type'(csr_paddr[3:2]);
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         case (idx)
            REG_VEHICLE_DIMENSION: cfg_in.vehicle_dimension = csr_pwdata[15:0];
            REG_TRACKING_DISTANCE: cfg_in.tracking_distance = csr_pwdata[15:0];
            REG_MAX_SPEED_STEP:    cfg_in.max_speed_step = csr_pwdata[15:0];
            REG_HISTORY_LIMIT:     cfg_in.history_limit = csr_pwdata[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_VEHICLE_DIMENSION: csr_prdata = {16'd0, cfg_ff.vehicle_dimension};
         REG_TRACKING_DISTANCE: csr_prdata = {16'd0, cfg_ff.tracking_distance};
         REG_MAX_SPEED_STEP:    csr_prdata = {16'd0, cfg_ff.max_speed_step};
         REG_HISTORY_LIMIT:     csr_prdata = {24'd0, cfg_ff.history_limit};
         default:               csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vehicle_dimension <= DIM_RESET;
         cfg_ff.tracking_distance <= TRACK_RESET;
         cfg_ff.max_speed_step <= STEP_RESET;
         cfg_ff.history_limit <= HISTORY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule
`default_nettype wire

/* hw/rtl/acsa_ctrl.sv */
`default_nettype none
module acsa_ctrl import acsa_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   input  sts_type   sts,
   output cmd_type   cmd
);
   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_DIV_K   = 8'b0000_0010,
      ST_MUL_LAT = 8'b0000_0100,
      ST_MUL_FWD = 8'b0000_1000,
      ST_EVAL    = 8'b0001_0000,
      ST_PREP    = 8'b0010_0000,
      ST_DIV_CMD = 8'b0100_0000,
      ST_DECIDE  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in = ST_DIV_K;
            end
         end
         ST_DIV_K: begin
            cmd.div_k = 1'b1;
            state_in = ST_MUL_LAT;
         end
         ST_MUL_LAT: begin
            cmd.mul_lat = 1'b1;
            state_in = ST_MUL_FWD;
         end
         ST_MUL_FWD: begin
            cmd.mul_fwd = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = sts.last_item ? ST_PREP : ST_IDLE;
         end
         ST_PREP: begin
            cmd.div_load_cmd = 1'b1;
            state_in = ST_DIV_CMD;
         end
         ST_DIV_CMD: begin
            cmd.div_cmd = 1'b1;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!sts.out_busy) begin
               cmd.decide = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

/* hw/rtl/acsa_dp.sv */
`default_nettype none
module acsa_dp import acsa_pkg::*; #(
   parameter int TRIG_TABLE_BITS = TRIG_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [47:0] req_tdata,
   input  wire logic        req_tuser,
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,
   input  cfg_type          cfg,
   input  cmd_type          cmd,
   output sts_type          sts
);
   localparam int B = TRIG_TABLE_BITS;
   localparam int QSTEPS = 1 << (B - 2);

   logic [15:0] sin_rom [QSTEPS+1];
   for (genvar i = 0; i <= QSTEPS; i++) begin : g_rom
      localparam logic [15:0] V = quarter_sine(i, B);
      assign sin_rom[i] = V;
   end

   logic signed [14:0] bearing_ff;
   logic [15:0] distance_ff, speed_ff;
   logic        first_ff, last_ff;
   logic [15:0] quo_ff, quo_in;
   logic [23:0] ncq_ff;
   logic        neg_ff;
   logic signed [33:0] lat_ff, fwd_ff;
   logic [15:0] nd_ff;
   logic signed [14:0] nb_ff;
   logic [16:0] nf_ff;
   logic        found_ff, brake_ff;
   logic        track_ff;
   logic signed [14:0] pb_ff;
   logic [15:0] pd_ff;
   logic [7:0]  cnt_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;

   // constant dividers by reciprocal multiplication
   logic [16:0] kx;
   logic [31:0] n_k;
   logic [42:0] k_prod;
   logic signed [29:0] num;
   logic [31:0] n_cmd;
   logic [47:0] cmd_prod;

   assign kx = 17'($signed({{2{bearing_ff[14]}}, bearing_ff}) +
               $signed(BEARING_OFFSET));
   assign n_k = (32'(kx) << (B + 1)) + K_ROUND;
   assign k_prod = 43'(n_k[30:10]) * 43'(K_RECIP);
   assign num = 30'(27'd1350 * speed_ff) + 30'(23'd90 * nf_ff)
              - 30'(20'd13 * cfg.vehicle_dimension);
   assign n_cmd = 32'($unsigned(num)) + CMD_ROUND;
   assign cmd_prod = 48'(ncq_ff) * 48'(CMD_RECIP);

   always_comb begin
      quo_in = quo_ff;
      if (cmd.div_k) begin
         quo_in = k_prod[42:27];
      end else if (cmd.div_cmd) begin
         quo_in = cmd_prod[47:32];
      end
   end

   // trig lookup
   logic [B-1:0] kk;
   logic [1:0]   quad;
   logic [B-3:0] rr;
   logic [B-2:0] tidx;
   logic signed [16:0] trig;
   logic signed [33:0] prod;

   assign kk = cmd.mul_fwd ? quo_ff[B-1:0] + (B)'(QSTEPS) : quo_ff[B-1:0];
   assign quad = kk[B-1:B-2];
   assign rr = kk[B-3:0];
   assign tidx = quad[0] ? ((B-1)'(QSTEPS) - {1'b0, rr}) : {1'b0, rr};
   assign trig = quad[1] ? -$signed({1'b0, sin_rom[tidx]}) : $signed({1'b0, sin_rom[tidx]});
   assign prod = $signed({1'b0, distance_ff}) * trig;

   // geometry
   logic [32:0] abs_lat;
   logic [39:0] dim_sh, lat10, lat15, fwd90, dim13;
   logic        fwd_pos, brake_hit, path_hit;
   logic [33:0] fwd_rnd;
   logic [15:0] nd_cur;

   assign abs_lat = lat_ff[33] ? 33'(-lat_ff) : 33'(lat_ff);
   assign dim_sh = 40'(cfg.vehicle_dimension) << 15;
   assign dim13 = 40'(cfg.vehicle_dimension) * 40'd13 << 15;
   assign lat10 = 40'(abs_lat) * 40'd10;
   assign lat15 = 40'(abs_lat) * 40'd15;
   assign fwd90 = 40'(fwd_ff[32:0]) * 40'd90;
   assign fwd_pos = !fwd_ff[33] && (fwd_ff != '0);
   assign brake_hit = fwd_pos && (lat10 < dim_sh) && (fwd90 < dim13);
   assign nd_cur = nd_ff;
   assign path_hit = !first_ff && fwd_pos && (lat15 < dim_sh) && (distance_ff < nd_cur);
   assign fwd_rnd = fwd_ff + 34'sd16384;

   // decision
   logic [7:0]  lim;
   logic signed [15:0] db;
   logic [15:0] abs_db;
   logic signed [16:0] dd;
   logic [16:0] abs_dd;
   logic [22:0] dd50;
   logic        same, present;
   logic [8:0]  cnt_next;
   logic [7:0]  cnt_new;
   logic [17:0] cmdv, hi, lo_test;
   logic [17:0] sugg;
   logic [15:0] sugg_out;

   assign lim = (cfg.history_limit == '0) ? 8'd1 : cfg.history_limit;
   assign db = 16'(nb_ff) - 16'(pb_ff);
   assign abs_db = db[15] ? 16'(-db) : 16'(db);
   assign dd = $signed({1'b0, nd_ff}) - $signed({1'b0, pd_ff});
   assign abs_dd = dd[16] ? 17'(-dd) : 17'(dd);
   assign dd50 = 23'(abs_dd) * 23'd50;
   assign same = track_ff && (abs_db < SAME_BEARING) &&
                 (dd50 < 23'(cfg.vehicle_dimension));
   assign cnt_next = same ? 9'(cnt_ff) + 9'd1 : 9'd1;
   assign cnt_new = (cnt_next > 9'(lim)) ? lim : cnt_next[7:0];
   assign present = found_ff && (nd_ff < cfg.tracking_distance);

   always_comb begin
      cmdv = neg_ff ? 18'd0 : 18'(quo_ff);
      hi = 18'(speed_ff) + 18'(cfg.max_speed_step);
      lo_test = cmdv + 18'(cfg.max_speed_step);
      sugg = cmdv;
      if (cmdv > hi) sugg = hi;
      if (lo_test < 18'(speed_ff)) sugg = 18'(speed_ff) - 18'(cfg.max_speed_step);
      sugg_out = (sugg > 18'd65535) ? 16'hFFFF : sugg[15:0];
   end

   assign sts.last_item = last_ff;
   assign sts.out_busy = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      if (cmd.accept) begin
         bearing_ff <= req_tdata[14:0];
         distance_ff <= req_tdata[30:15];
         speed_ff <= req_tdata[46:31];
         first_ff <= req_tuser;
         last_ff <= req_tlast;
      end
      if (cmd.div_load_cmd) begin
         ncq_ff <= n_cmd[26:3];
         neg_ff <= num[29];
      end
      if (cmd.mul_lat) lat_ff <= prod;
      if (cmd.mul_fwd) fwd_ff <= prod;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nd_ff <= DIM_RESET;
         nb_ff <= '0;
         nf_ff <= '0;
         found_ff <= 1'b0;
         brake_ff <= 1'b0;
         track_ff <= 1'b0;
         pb_ff <= '0;
         pd_ff <= '0;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff <= '0;
      end else begin
         if (cmd.decide) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.accept && req_tuser) begin
            nd_ff <= cfg.vehicle_dimension;
            nb_ff <= '0;
            nf_ff <= '0;
            found_ff <= 1'b0;
            brake_ff <= 1'b0;
         end
         if (cmd.eval) begin
            if (brake_hit) brake_ff <= 1'b1;
            if (path_hit) begin
               nd_ff <= distance_ff;
               nb_ff <= bearing_ff;
               nf_ff <= fwd_rnd[31:15];
               found_ff <= 1'b1;
            end
         end
         if (cmd.decide) begin
            if (brake_ff) begin
               rsp_data_ff <= {5'd0, cnt_ff, 1'b0, 1'b0, 1'b1, 1'b0, speed_ff[15:1]};
            end else if (present) begin
               cnt_ff <= cnt_new;
               track_ff <= 1'b1;
               pb_ff <= nb_ff;
               pd_ff <= nd_ff;
               rsp_data_ff <= {5'd0, cnt_new, !same, 1'b1, 1'b0, sugg_out};
            end else begin
               track_ff <= 1'b0;
               cnt_ff <= '0;
               rsp_data_ff <= {5'd0, 8'd0, 1'b0, 1'b0, 1'b0, speed_ff};
            end
            nd_ff <= cfg.vehicle_dimension;
            nb_ff <= '0;
            nf_ff <= '0;
            found_ff <= 1'b0;
            brake_ff <= 1'b0;
         end
      end
   end
endmodule
`default_nettype wire

/* hw/rtl/adaptive_cruise_speed_advisor_core.sv */
`default_nettype none
// Adaptive cruise speed advisor.
// Input stream (req_): one request per observation of a perception frame.
//   req_tuser marks the frame's first observation, req_tlast its last.
// Output stream (rsp_): one result per frame, issued after the last request.
// Config (csr_): APB-style registers at 0x0 vehicle dimension, 0x4 tracking
//   distance, 0x8 max speed step, 0xC history limit; write only while idle.
// Sequence: an observation passes the accept step, a reciprocal multiply for
//   the table index, two multiplies on one shared multiplier and a compare.
//   A last observation then adds the speed command prepare, reciprocal
//   multiply and decision steps; its result is valid once the decision is
//   registered.
// The sequential controller takes no new request until it has finished the
//   current one, including the decision for a last request.
// Reset clears the tracking history, the frame accumulators and restores the
//   register defaults; the block is ready as soon as reset drops.
// A stalled result is held in the output register; the next frame's requests
//   are still processed, and only the next result waits for it to drain,
//   holding off further requests meanwhile.
module adaptive_cruise_speed_advisor_core import acsa_pkg::*; #(
   parameter int TRIG_TABLE_BITS = TRIG_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [47:0]              req_tdata,  // bearing, distance, own_speed
   input  wire logic                     req_tuser,  // first_item
   input  wire logic                     req_tlast,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // suggested_speed, emergency, target_present, new_target, history_count
   output logic      [31:0]              rsp_tdata,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                          csr_pready
);
   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   acsa_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cfg
   );

   acsa_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .sts, .cmd
   );

   acsa_dp #(.TRIG_TABLE_BITS(TRIG_TABLE_BITS)) u_dp (
      .clock, .reset, .req_tdata, .req_tuser, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .cfg, .cmd, .sts
   );
endmodule
`default_nettype wire

/* verif/adaptive_cruise_speed_advisor_core_test.sv */
`timescale 1ns / 1ps
module adaptive_cruise_speed_advisor_core_test;
   import acsa_pkg::*;

   typedef struct {
      bit                 is_cfg;
      reg_index_type      reg_idx;
      logic [31:0]        value;
      logic signed [14:0] bearing;
      logic [15:0]        distance;
      bit                 first;
      bit                 last;
      logic [15:0]        speed;
   } obs_t;

   typedef struct {
      logic [15:0] speed;
      bit          emergency;
      bit          present;
      bit          fresh;
      logic [7:0]  history;
   } advice_t;

   localparam int QSTEPS = 256;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 60;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic        csr_pready;

   adaptive_cruise_speed_advisor_core DUT (.*);

   always #10 clock = ~clock;

   obs_t    pending_obs[$];
   advice_t expected_advice[$];
   obs_t    cur_obs;
   int      req_gap = 0;
   int      rsp_stall = 0;
   int      quiet = 0;
   int      cfg_phase = 0;
   int      accepted_count = 0;
   int      calm_mark = 1 << 30;
   int      fail_count = 0;
   int      frame_count = 0;
   int      emergency_count = 0;
   int      target_count = 0;
   int      cfg_writes = 0;
   int      gen_dim = 450;
   int      idle_cycles = 0;

   // predictor state
   longint dim_cfg, track_cfg, step_cfg, hist_cfg;
   longint near_dist, near_bear, near_fwd, prev_bear, prev_dist, same_count;
   bit     found, braking, tracking;

   function automatic longint abs_l(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint quarter_wave(longint unsigned r);
      longint unsigned x, x2, t, s, one;
      longint unsigned dv[5];
      dv = '{110, 72, 42, 20, 6};
      one = 64'd1 << 30;
      x = (r * 64'd1686629713) / QSTEPS;
      x2 = (x * x) >> 30;
      t = one;
      for (int i = 0; i < 5; i++) t = one - ((x2 * t) >> 30) / dv[i];
      s = (x * t) >> 30;
      s = (s + 64'd16384) >> 15;
      return s > 32768 ? 32768 : longint'(s);
   endfunction

   function automatic longint sine_step(longint unsigned k);
      longint unsigned q, r;
      longint mag;
      k = k & 1023;
      q = (k >> 8) & 3;
      r = k & 255;
      mag = q[0] ? quarter_wave(QSTEPS - r) : quarter_wave(r);
      return q >= 2 ? -mag : mag;
   endfunction

   function automatic void clear_frame_state();
      near_dist = dim_cfg;
      near_bear = 0;
      near_fwd = 0;
      found = 0;
      braking = 0;
   endfunction

   function automatic void reset_advisor();
      dim_cfg = 450; track_cfg = 5000; step_cfg = 100; hist_cfg = 10;
      clear_frame_state();
      tracking = 0; prev_bear = 0; prev_dist = 0; same_count = 0;
   endfunction

   function automatic bit advise_observation(obs_t o, output advice_t a);
      longint b, d, spd, lat, fwd, num, cmd, lim;
      longint unsigned k;
      bit same;
      b = longint'(o.bearing);
      d = o.distance;
      spd = o.speed;
      a = '{default: 0};
      if (o.first) clear_frame_state();
      k = (($unsigned(b + 46080) << 11) + 23040) / 46080;
      lat = d * sine_step(k);
      fwd = d * sine_step(k + QSTEPS);
      if (fwd > 0 && abs_l(lat) * 10 < dim_cfg * 32768 && fwd * 90 < 13 * dim_cfg * 32768)
         braking = 1;
      if (!o.first && fwd > 0 && abs_l(lat) * 15 < dim_cfg * 32768 && d < near_dist) begin
         near_dist = d;
         near_bear = b;
         near_fwd = (fwd + 16384) >>> 15;
         found = 1;
      end
      if (!o.last) return 0;
      if (braking) begin
         a.speed = 16'(spd >> 1);
      end else if (found && near_dist < track_cfg) begin
         lim = hist_cfg == 0 ? 1 : hist_cfg;
         same = tracking && abs_l(near_bear - prev_bear) < 640
                && abs_l(near_dist - prev_dist) * 50 < dim_cfg;
         same_count = same ? same_count + 1 : 1;
         if (same_count > lim) same_count = lim;
         tracking = 1;
         prev_bear = near_bear;
         prev_dist = near_dist;
         a.present = 1;
         a.fresh = !same;
         num = 1350 * spd + 90 * near_fwd - 13 * dim_cfg;
         cmd = num < 0 ? 0 : (num + 900) / 1800;
         if (cmd - spd > step_cfg) cmd = spd + step_cfg;
         if (spd - cmd > step_cfg) cmd = spd - step_cfg;
         if (cmd > 65535) cmd = 65535;
         if (cmd < 0) cmd = 0;
         a.speed = 16'(cmd);
      end else begin
         tracking = 0;
         same_count = 0;
         a.speed = 16'(spd);
      end
      a.emergency = braking;
      a.history = 8'(same_count);
      clear_frame_state();
      return 1;
   endfunction

   task automatic add_obs(int b, int d, bit first, bit last, int spd);
      obs_t o;
      o.is_cfg = 1'b0;
      o.reg_idx = REG_VEHICLE_DIMENSION;
      o.value = '0;
      o.bearing = 15'(b);
      o.distance = 16'(d);
      o.first = first;
      o.last = last;
      o.speed = 16'(spd);
      pending_obs.push_back(o);
   endtask

   task automatic add_cfg(reg_index_type idx, int val);
      obs_t o;
      o.is_cfg = 1'b1;
      o.reg_idx = idx;
      o.value = val;
      o.bearing = '0;
      o.distance = '0;
      o.first = 1'b0;
      o.last = 1'b0;
      o.speed = '0;
      if (idx == REG_VEHICLE_DIMENSION) gen_dim = val;
      pending_obs.push_back(o);
   endtask

   function automatic int clamp_u16(int v);
      return v < 0 ? 0 : (v > 65535 ? 65535 : v);
   endfunction

   function automatic int rnd_signed(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   task automatic gen_frames(int n);
      int sent, cnt, tb, td, span, b, d, spd, kind;
      bit nofirst, first, last;
      sent = 0;
      tb = 0;
      td = gen_dim / 2;
      while (sent < n) begin
         if ($urandom_range(0, 19) == 0) begin
            add_obs(rnd_signed(11520), $urandom_range(0, 65535), $urandom_range(0, 1) == 1,
                    $urandom_range(0, 1) == 1, $urandom_range(0, 65535));
            sent++;
            continue;
         end
         span = gen_dim * 2 > 65535 ? 65535 : gen_dim * 2;
         if ($urandom_range(0, 7) == 0) begin
            tb = rnd_signed(300);
            td = $urandom_range(0, span);
         end else begin
            tb = tb + rnd_signed(150);
            td = clamp_u16(td + rnd_signed(gen_dim / 40 + 1));
         end
         cnt = $urandom_range(1, 6);
         nofirst = $urandom_range(0, 9) == 0;
         for (int i = 0; i < cnt; i++) begin
            first = (i == 0) && !nofirst;
            last = i == cnt - 1;
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
               b = tb;
               d = td;
            end else if (kind < 5) begin
               b = rnd_signed(100);
               d = $urandom_range(0, gen_dim * 13 / 90 + 2);
            end else if (kind < 8) begin
               b = rnd_signed(400);
               d = $urandom_range(0, span);
            end else begin
               b = rnd_signed(11520);
               d = $urandom_range(0, 65535);
            end
            spd = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 4000);
            add_obs(b, d, first, last, spd);
            sent++;
         end
      end
   endtask

   task automatic set_all(int dim, int track, int step, int hist);
      add_cfg(REG_VEHICLE_DIMENSION, dim);
      add_cfg(REG_TRACKING_DISTANCE, track);
      add_cfg(REG_MAX_SPEED_STEP, step);
      add_cfg(REG_HISTORY_LIMIT, hist);
   endtask

   // driver: requests and register writes
   always @(posedge clock) begin
      advice_t a;
      bit hold;
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_psel <= 1'b0;
         csr_penable <= 1'b0;
         cfg_phase = 0;
         quiet = 0;
      end else begin
         hold = req_tvalid && !req_tready;
         quiet = ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) ? 0 : quiet + 1;
         if (req_tvalid && req_tready) begin
            if (advise_observation(cur_obs, a)) begin
               expected_advice.push_back(a);
               frame_count++;
               emergency_count += a.emergency;
               target_count += a.present;
            end
            accepted_count++;
         end
         if (cfg_phase == 2) begin
            if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
               case (cur_obs.reg_idx)
                  REG_VEHICLE_DIMENSION: dim_cfg = cur_obs.value[15:0];
                  REG_TRACKING_DISTANCE: track_cfg = cur_obs.value[15:0];
                  REG_MAX_SPEED_STEP:    step_cfg = cur_obs.value[15:0];
                  REG_HISTORY_LIMIT:     hist_cfg = cur_obs.value[7:0];
                  default: ;
               endcase
               cfg_writes++;
               csr_psel <= 1'b0;
               csr_penable <= 1'b0;
               cfg_phase = 0;
            end
         end else if (cfg_phase == 1) begin
            csr_penable <= 1'b1;
            cfg_phase = 2;
         end else if (!hold) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_obs.size() > 0 && !pending_obs[0].is_cfg) begin
               cur_obs = pending_obs.pop_front();
               req_tdata <= {1'b0, cur_obs.speed, cur_obs.distance, cur_obs.bearing};
               req_tuser <= cur_obs.first;
               req_tlast <= cur_obs.last;
               req_tvalid <= 1'b1;
               if (accepted_count < calm_mark && $urandom_range(0, 3) == 0)
                  req_gap = $urandom_range(1, 6);
            end else begin
               req_tvalid <= 1'b0;
               if (pending_obs.size() > 0 && !req_tvalid && expected_advice.size() == 0
                   && quiet >= SETTLE_CYCLES) begin
                  cur_obs = pending_obs.pop_front();
                  csr_psel <= 1'b1;
                  csr_pwrite <= 1'b1;
                  csr_penable <= 1'b0;
                  csr_paddr <= CSR_ADDR_BITS'({cur_obs.reg_idx, 2'b00});
                  csr_pwdata <= cur_obs.value;
                  cfg_phase = 1;
               end
            end
         end
      end
   end

   // monitor: results
   always @(posedge clock) begin
      advice_t e;
      advice_t g;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            g.speed = rsp_tdata[15:0];
            g.emergency = rsp_tdata[16];
            g.present = rsp_tdata[17];
            g.fresh = rsp_tdata[18];
            g.history = rsp_tdata[26:19];
            if (expected_advice.size() == 0) begin
               $error("unexpected result %h", rsp_tdata);
               fail_count++;
            end else begin
               e = expected_advice.pop_front();
               if (g.speed !== e.speed) begin
                  $error("suggested_speed: expected %0d, got %0d", e.speed, g.speed);
                  fail_count++;
               end
               if (g.emergency !== e.emergency) begin
                  $error("emergency: expected %0d, got %0d", e.emergency, g.emergency);
                  fail_count++;
               end
               if (g.present !== e.present) begin
                  $error("target_present: expected %0d, got %0d", e.present, g.present);
                  fail_count++;
               end
               if (g.fresh !== e.fresh) begin
                  $error("new_target: expected %0d, got %0d", e.fresh, g.fresh);
                  fail_count++;
               end
               if (g.history !== e.history) begin
                  $error("history_count: expected %0d, got %0d", e.history, g.history);
                  fail_count++;
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (accepted_count < calm_mark && $urandom_range(0, 4) == 0)
               rsp_stall = $urandom_range(1, 6);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int total;
      reset_advisor();
      // brake box hit with first and last together
      add_obs(0, 50, 1, 1, 65535);
      add_obs(-11520, 65535, 1, 0, 1000);
      add_obs(0, 300, 0, 0, 0);
      add_obs(11520, 0, 0, 1, 0);
      add_obs(0, 200, 1, 0, 0);
      add_obs(64, 310, 0, 0, 0);
      add_obs(-11520, 100, 0, 1, 65535);
      // frame with no first item
      add_obs(0, 400, 0, 0, 0);
      add_obs(0, 1000, 0, 1, 3000);
      add_obs(5760, 100, 1, 0, 0);
      add_obs(-5760, 100, 0, 1, 1234);
      // nearest tie keeps the earlier one
      add_obs(0, 10000, 1, 0, 0);
      add_obs(10, 300, 0, 0, 0);
      add_obs(-10, 300, 0, 0, 0);
      add_obs(0, 0, 0, 1, 2000);
      add_obs(-1, 350, 1, 0, 0);
      add_obs(-1, 320, 0, 0, 0);
      add_obs(1, 65535, 0, 1, 40000);
      add_obs(-16384, 5, 1, 1, 7);
      gen_frames(300);
      set_all(65535, 65535, 0, 1);
      gen_frames(300);
      set_all(1, 0, 65535, 255);
      gen_frames(250);
      set_all($urandom_range(100, 3000), $urandom_range(500, 20000), $urandom_range(0, 500), 0);
      gen_frames(350);
      set_all($urandom_range(50, 5000), $urandom_range(0, 65535), $urandom_range(0, 2000),
              $urandom_range(1, 20));
      gen_frames(350);
      set_all(800, 20000, 65535, 3);
      add_cfg(REG_HISTORY_LIMIT, 2);
      gen_frames(380);
      total = 0;
      foreach (pending_obs[i]) total += !pending_obs[i].is_cfg;
      calm_mark = total * 9 / 10;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      while (pending_obs.size() > 0 || req_tvalid || cfg_phase != 0 || expected_advice.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_advice.size() > 0) begin
         $error("%0d results never arrived", expected_advice.size());
         fail_count++;
      end
      $display("Covered %0d requests, %0d frames (%0d emergencies, %0d tracked targets)",
               accepted_count, frame_count, emergency_count, target_count);
      $display("across %0d register writes spanning extreme and random settings", cfg_writes);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
